// ===== rtl/cgfn_pkg.sv =====
// Shared types, constants and S-box/GF(2^8) helpers for the CLEFIA GFN4 core.
`default_nettype none
package cgfn_pkg;

  localparam int ROUNDS_W = 5;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd18;

  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_ENC  = 2'd1;
  localparam logic [1:0] FN_DEC  = 2'd2;

  localparam logic [7:0] POLY_LOW = 8'h1D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic wr_odd;
    logic rd_en;
  } kmem_ctl_t;

  localparam logic [3:0] NIB_A [16] = '{4'he, 4'h6, 4'hc, 4'ha, 4'h8, 4'h7, 4'h2, 4'hf,
                                        4'hb, 4'h1, 4'h4, 4'h0, 4'h5, 4'h9, 4'hd, 4'h3};
  localparam logic [3:0] NIB_B [16] = '{4'h6, 4'h4, 4'h0, 4'hd, 4'h2, 4'hb, 4'ha, 4'h3,
                                        4'h9, 4'hc, 4'he, 4'hf, 4'h8, 4'h7, 4'h5, 4'h1};
  localparam logic [3:0] NIB_C [16] = '{4'hb, 4'h8, 4'h5, 4'he, 4'ha, 4'h6, 4'h4, 4'hc,
                                        4'hf, 4'h7, 4'h2, 4'h3, 4'h1, 4'h0, 4'hd, 4'h9};
  localparam logic [3:0] NIB_D [16] = '{4'ha, 4'h2, 4'h6, 4'hd, 4'h3, 4'h4, 4'h5, 4'he,
                                        4'h0, 4'h7, 4'h8, 4'h9, 4'hb, 4'hf, 4'hc, 4'h1};

  // Diffusion matrices, row-major; index 0 is M0 (F0), index 1 is M1 (F1).
  localparam logic [3:0] MIX [2][16] = '{
    '{4'd1, 4'd2, 4'd4, 4'd6, 4'd2, 4'd1, 4'd6, 4'd4,
      4'd4, 4'd6, 4'd1, 4'd2, 4'd6, 4'd4, 4'd2, 4'd1},
    '{4'd1, 4'd8, 4'd2, 4'd10, 4'd8, 4'd1, 4'd10, 4'd2,
      4'd2, 4'd10, 4'd1, 4'd8, 4'd10, 4'd2, 4'd8, 4'd1}
  };

  localparam logic [7:0] SBOX1 [256] = '{
    8'h6c,8'hda,8'hc3,8'he9,8'h4e,8'h9d,8'h0a,8'h3d,8'hb8,8'h36,8'hb4,8'h38,8'h13,8'h34,8'h0c,8'hd9,
    8'hbf,8'h74,8'h94,8'h8f,8'hb7,8'h9c,8'he5,8'hdc,8'h9e,8'h07,8'h49,8'h4f,8'h98,8'h2c,8'hb0,8'h93,
    8'h12,8'heb,8'hcd,8'hb3,8'h92,8'he7,8'h41,8'h60,8'he3,8'h21,8'h27,8'h3b,8'he6,8'h19,8'hd2,8'h0e,
    8'h91,8'h11,8'hc7,8'h3f,8'h2a,8'h8e,8'ha1,8'hbc,8'h2b,8'hc8,8'hc5,8'h0f,8'h5b,8'hf3,8'h87,8'h8b,
    8'hfb,8'hf5,8'hde,8'h20,8'hc6,8'ha7,8'h84,8'hce,8'hd8,8'h65,8'h51,8'hc9,8'ha4,8'hef,8'h43,8'h53,
    8'h25,8'h5d,8'h9b,8'h31,8'he8,8'h3e,8'h0d,8'hd7,8'h80,8'hff,8'h69,8'h8a,8'hba,8'h0b,8'h73,8'h5c,
    8'h6e,8'h54,8'h15,8'h62,8'hf6,8'h35,8'h30,8'h52,8'ha3,8'h16,8'hd3,8'h28,8'h32,8'hfa,8'haa,8'h5e,
    8'hcf,8'hea,8'hed,8'h78,8'h33,8'h58,8'h09,8'h7b,8'h63,8'hc0,8'hc1,8'h46,8'h1e,8'hdf,8'ha9,8'h99,
    8'h55,8'h04,8'hc4,8'h86,8'h39,8'h77,8'h82,8'hec,8'h40,8'h18,8'h90,8'h97,8'h59,8'hdd,8'h83,8'h1f,
    8'h9a,8'h37,8'h06,8'h24,8'h64,8'h7c,8'ha5,8'h56,8'h48,8'h08,8'h85,8'hd0,8'h61,8'h26,8'hca,8'h6f,
    8'h7e,8'h6a,8'hb6,8'h71,8'ha0,8'h70,8'h05,8'hd1,8'h45,8'h8c,8'h23,8'h1c,8'hf0,8'hee,8'h89,8'had,
    8'h7a,8'h4b,8'hc2,8'h2f,8'hdb,8'h5a,8'h4d,8'h76,8'h67,8'h17,8'h2d,8'hf4,8'hcb,8'hb1,8'h4a,8'ha8,
    8'hb5,8'h22,8'h47,8'h3a,8'hd5,8'h10,8'h4c,8'h72,8'hcc,8'h00,8'hf9,8'he0,8'hfd,8'he2,8'hfe,8'hae,
    8'hf8,8'h5f,8'hab,8'hf1,8'h1b,8'h42,8'h81,8'hd6,8'hbe,8'h44,8'h29,8'ha6,8'h57,8'hb9,8'haf,8'hf2,
    8'hd4,8'h75,8'h66,8'hbb,8'h68,8'h9f,8'h50,8'h02,8'h01,8'h3c,8'h7f,8'h8d,8'h1a,8'h88,8'hbd,8'hac,
    8'hf7,8'he4,8'h79,8'h96,8'ha2,8'hfc,8'h6d,8'hb2,8'h6b,8'h03,8'he1,8'h2e,8'h7d,8'h14,8'h95,8'h1d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? POLY_LOW : 8'h00);
  endfunction

  // Multiply by a 4-bit constant in GF(2^8).
  function automatic logic [7:0] gmulc(input logic [7:0] b, input logic [3:0] c);
    logic [7:0] acc;
    logic [7:0] t;
    acc = 8'h00;
    t   = b;
    for (int i = 0; i < 4; i++) begin
      if (c[i]) acc = acc ^ t;
      t = xtime(t);
    end
    return acc;
  endfunction

  function automatic logic [3:0] twice4(input logic [3:0] v);
    return {v[2:0], 1'b0} ^ (v[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic logic [7:0] sbox0(input logic [7:0] x);
    logic [3:0] hi;
    logic [3:0] lo;
    logic [3:0] u0;
    logic [3:0] u1;
    hi = NIB_A[x[7:4]];
    lo = NIB_B[x[3:0]];
    u0 = hi ^ twice4(lo);
    u1 = twice4(hi) ^ lo;
    return {NIB_C[u0], NIB_D[u1]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cgfn_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`default_nettype none
interface cgfn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  key_index;
  logic [31:0] key_word;
  logic [31:0] in_word0;
  logic [31:0] in_word1;
  logic [31:0] in_word2;
  logic [31:0] in_word3;

  modport source(output valid, func, key_index, key_word, in_word0, in_word1, in_word2,
                 in_word3, input ready);
  modport sink(input valid, func, key_index, key_word, in_word0, in_word1, in_word2,
               in_word3, output ready);
endinterface

interface cgfn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;

  modport source(output valid, out_word0, out_word1, out_word2, out_word3, input ready);
  modport sink(input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface
`default_nettype wire

// ===== rtl/clefia_gfn4_data_rounds.sv =====
// CLEFIA GFN4 data-round core: top level with round sequencer and result register.
// Load item: written to the key memory if key_index is below 2*MAX_ROUNDS, no result.
// Encrypt/decrypt item: r = min(rounds, MAX_ROUNDS) rounds at one round per cycle, set by
// the one-pair-per-cycle read of the key memory; the result is registered from ST_FIN.
// Items are accepted only in ST_IDLE, after the last result is registered, even while it waits.
// Synchronous reset clears control and sets rounds to 18; the key memory is not cleared.
`default_nettype none
module clefia_gfn4_data_rounds import cgfn_pkg::*; #(
  parameter int MAX_ROUNDS = 26
) (
  input  logic                clk,
  input  logic                rst,
  cgfn_in_if.sink             in_ch,
  cgfn_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [ROUNDS_W-1:0] cfg_wdata
);

  localparam int AW          = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int CW          = $clog2(MAX_ROUNDS + 1);
  localparam int STORE_DEPTH = 2 * MAX_ROUNDS;

  state_t              state;
  state_t              state_next;
  logic [ROUNDS_W-1:0] rounds;
  logic [CW-1:0]       r_sat;
  logic [CW-1:0]       left;
  logic [AW-1:0]       kaddr;
  logic [AW-1:0]       kaddr_step;
  logic [AW-1:0]       kaddr_first;
  logic [AW-1:0]       rd_addr;
  logic                dec;
  logic [31:0]         t0, t1, t2, t3;
  logic [31:0]         f0, f1, u1, u3;
  logic [31:0]         k_even, k_odd;
  logic                in_acc;
  logic                run;
  logic                last;
  logic                out_free;
  logic                out_valid;
  logic [31:0]         o0, o1, o2, o3;
  kmem_ctl_t           kctl;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign run      = in_acc && (in_ch.func == FN_ENC || in_ch.func == FN_DEC);
  assign last     = (left == CW'(1));
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    if (int'(rounds) > MAX_ROUNDS) r_sat = CW'(MAX_ROUNDS);
    else r_sat = CW'(rounds);
  end

  assign kaddr_first = (in_ch.func == FN_DEC) ? AW'(r_sat - CW'(1)) : '0;
  assign kaddr_step  = dec ? kaddr - AW'(1) : kaddr + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) rounds <= ROUNDS_RESET;
    else if (cfg_we) rounds <= cfg_wdata;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (run) state_next = (r_sat == '0) ? ST_FIN : ST_ROUND;
      end
      ST_ROUND: begin
        if (last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    kctl.rd_en  = 1'b0;
    kctl.wr_en  = 1'b0;
    kctl.wr_odd = in_ch.key_index[0];
    rd_addr     = kaddr_step;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = kaddr_first;
        kctl.rd_en  = in_ch.valid && (in_ch.func == FN_ENC || in_ch.func == FN_DEC) &&
                      (r_sat != '0);
        kctl.wr_en  = in_ch.valid && in_ch.func == FN_LOAD &&
                      int'(in_ch.key_index) < STORE_DEPTH;
      end
      ST_ROUND: begin
        kctl.rd_en = !last;
      end
      ST_FIN: begin
        kctl.rd_en = 1'b0;
      end
      default: begin
        kctl.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  cgfn_key_mem #(
    .DEPTH (MAX_ROUNDS),
    .AW    (AW)
  ) u_key_mem (
    .clk     (clk),
    .ctl     (kctl),
    .wr_addr (in_ch.key_index[AW:1]),
    .wr_data (in_ch.key_word),
    .rd_addr (rd_addr),
    .rd_even (k_even),
    .rd_odd  (k_odd)
  );

  cgfn_ffunc #(.IS_F1(1'b0)) u_f0 (.key(k_even), .x(t0), .y(f0));
  cgfn_ffunc #(.IS_F1(1'b1)) u_f1 (.key(k_odd), .x(t2), .y(f1));

  assign u1 = t1 ^ f0;
  assign u3 = t3 ^ f1;

  // branch registers and round sequencing
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && run) begin
      t0    <= in_ch.in_word0;
      t1    <= in_ch.in_word1;
      t2    <= in_ch.in_word2;
      t3    <= in_ch.in_word3;
      dec   <= (in_ch.func == FN_DEC);
      left  <= r_sat;
      kaddr <= kaddr_first;
    end else if (state == ST_ROUND) begin
      left  <= left - CW'(1);
      kaddr <= kaddr_step;
      if (dec) begin
        t0 <= u3;
        t1 <= t0;
        t2 <= u1;
        t3 <= t2;
      end else begin
        t0 <= u1;
        t1 <= t2;
        t2 <= u3;
        t3 <= t0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      if (dec) begin
        o0 <= t1;
        o1 <= t2;
        o2 <= t3;
        o3 <= t0;
      end else begin
        o0 <= t3;
        o1 <= t0;
        o2 <= t1;
        o3 <= t2;
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_word0 = o0;
  assign out_ch.out_word1 = o1;
  assign out_ch.out_word2 = o2;
  assign out_ch.out_word3 = o3;

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> (left != '0 && int'(left) <= MAX_ROUNDS))
    else $error("round counter out of range");

  a_rd_addr_range: assert property (@(posedge clk) disable iff (rst)
    kctl.rd_en |-> int'(rd_addr) < MAX_ROUNDS)
    else $error("key read address beyond store");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside final state");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    kctl.wr_en |-> in_ch.ready && state == ST_IDLE)
    else $error("key write while rounds in progress");

endmodule
`default_nettype wire

// ===== rtl/cgfn_key_mem.sv =====
// Round-key memory: even and odd key banks, one write port, registered read of a pair.
`default_nettype none
module cgfn_key_mem import cgfn_pkg::*; #(
  parameter int DEPTH = 26,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  kmem_ctl_t     ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_even,
  output logic [31:0]   rd_odd
);

  logic [31:0] mem_even [DEPTH];
  logic [31:0] mem_odd  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.wr_odd) mem_even[wr_addr] <= wr_data;
    if (ctl.wr_en && ctl.wr_odd) mem_odd[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_even <= mem_even[rd_addr];
      rd_odd  <= mem_odd[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cgfn_ffunc.sv =====
// CLEFIA F-function: key add, S0/S1 layer, diffusion matrix M0 (F0) or M1 (F1).
`default_nettype none
module cgfn_ffunc import cgfn_pkg::*; #(
  parameter bit IS_F1 = 1'b0
) (
  input  logic [31:0] key,
  input  logic [31:0] x,
  output logic [31:0] y
);

  localparam int MSEL = IS_F1 ? 1 : 0;

  always_comb begin
    logic [31:0] v;
    logic [7:0]  b [4];
    logic [7:0]  acc;
    logic        use_s1;
    v = key ^ x;
    y = '0;
    for (int k = 0; k < 4; k++) begin
      use_s1 = ((k % 2) == 0) ? IS_F1 : !IS_F1;
      b[k] = use_s1 ? SBOX1[v[31-8*k -: 8]] : sbox0(v[31-8*k -: 8]);
    end
    for (int j = 0; j < 4; j++) begin
      acc = 8'h00;
      for (int k = 0; k < 4; k++) begin
        acc = acc ^ gmulc(b[k], MIX[MSEL][j*4+k]);
      end
      y[31-8*j -: 8] = acc;
    end
  end

endmodule
`default_nettype wire
